/* rtl/wbps_pkg.sv */
// Shared constants, types and helpers for the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int DEFAULT_MAX_PATTERN_BYTES = 32;
   localparam int PATTERN_WORDS             = 4;
   localparam int PATTERN_REG_BYTES         = 8 * PATTERN_WORDS;
   localparam int ADDR_W                    = 64;
   localparam int CSR_INDEX_W               = 3;
   localparam int CSR_DATA_W                = 64;
   localparam int LEN_REG_W                 = 6;

   localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_BASE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD_0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD_1  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD_2  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD_3  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WILDCARD_ENABLE = 3'd6;

   typedef logic [PATTERN_WORDS-1:0][63:0] pattern_words_type;

   // Pattern byte at position idx; bytes past the register file read as zero.
   function automatic logic [7:0] pattern_byte(input pattern_words_type words,
                                               input logic [6:0] idx);
      logic [7:0] b;
      if (idx >= 7'(PATTERN_REG_BYTES)) begin
         b = 8'h00;
      end else begin
         b = words[idx[4:3]][{idx[2:0], 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage

/* rtl/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner: one module, window, compare and result stage.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | tdata[7:0] data_byte, tlast last_byte
//   rsp     | out       | rsp_tvalid/rsp_tready | tuser[0] found, tdata[63:0] match_address
//   csr     | in        | csr_valid/csr_ready   | csr_index register number, csr_data value
//
// A byte beat is taken into an input register and from there shifted into the byte
// window, compared against the pattern in parallel and, when a result is due, written to the
// result register, from which it leaves on rsp.
// One byte is accepted per cycle while results drain; the result register is the only point
// where a stall on rsp backs up into req. Reset is synchronous and active high: it clears the
// configuration to its defaults, the byte count, the match flag and both valid flags.
// The configuration port is always ready and takes one register write per cycle.
module wildcard_byte_pattern_scanner #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input byte stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wbps_pkg::ADDR_W-1:0]         rsp_tdata,   // [63:0] match_address
   output logic                                rsp_tuser,   // [0] found
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]     csr_data
);
   import wbps_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

   // Configuration registers.
   logic [ADDR_W-1:0]     region_base_ff;
   pattern_words_type     pattern_words_ff;
   logic [LEN_REG_W-1:0]  pattern_length_ff;
   logic                  wildcard_enable_ff;

   // Input register.
   logic                  in_valid_ff;
   logic [7:0]            in_data_ff;
   logic                  in_last_ff;

   // Scan state.
   logic [MAX_PATTERN_BYTES-1:0][7:0] window_ff;
   logic [MAX_PATTERN_BYTES-1:0][7:0] window_in;
   logic [ADDR_W-1:0]     bytes_seen_ff;
   logic [ADDR_W-1:0]     bytes_seen_in;
   logic                  match_done_ff;

   // Result register.
   logic                  out_valid_ff;
   logic                  out_found_ff;
   logic [ADDR_W-1:0]     out_addr_ff;

   logic                  advance;
   logic [LEN_W-1:0]      active_len;
   logic [MAX_PATTERN_BYTES-1:0][7:0] aligned_pat;
   logic [MAX_PATTERN_BYTES-1:0]      care;
   logic                  window_hit;
   logic                  hit;
   logic                  emit;
   logic [ADDR_W-1:0]     match_addr;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = out_addr_ff;

   // Pattern length in use: zero acts as one, anything beyond the window acts as its size.
   always_comb begin
      if (pattern_length_ff == '0) begin
         active_len = LEN_W'(1);
      end else if (int'(pattern_length_ff) > MAX_PATTERN_BYTES) begin
         active_len = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         active_len = LEN_W'(pattern_length_ff);
      end
   end

   // The newest byte sits in window slot 0, so pattern byte j lines up with slot len-1-j.
   // Aligning the pattern here depends on configuration only, keeping the byte path short.
   always_comb begin
      logic [6:0] j;
      logic [7:0] p;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         j = 7'(active_len) - 7'd1 - 7'(i);
         p = pattern_byte(pattern_words_ff, j);
         aligned_pat[i] = p;
         care[i] = (i < int'(active_len)) && !(wildcard_enable_ff && (p == WILDCARD_BYTE));
      end
   end

   // Window shift and saturating byte count.
   always_comb begin
      window_in[0] = in_data_ff;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         window_in[i] = window_ff[i-1];
      end
      bytes_seen_in = (bytes_seen_ff == '1) ? bytes_seen_ff : bytes_seen_ff + ADDR_W'(1);
   end

   // Parallel compare of every slot in use against its aligned pattern byte.
   always_comb begin
      window_hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if (care[i] && (window_in[i] != aligned_pat[i])) begin
            window_hit = 1'b0;
         end
      end
   end

   // A region shorter than the pattern can never match, old window bytes included.
   assign hit        = !match_done_ff && (bytes_seen_in >= ADDR_W'(active_len)) && window_hit;
   assign emit       = hit || (!match_done_ff && in_last_ff);
   assign match_addr = region_base_ff + (bytes_seen_in - ADDR_W'(active_len));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff     <= '0;
         pattern_words_ff   <= '0;
         pattern_length_ff  <= LEN_REG_W'(1);
         wildcard_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_REGION_BASE:     region_base_ff      <= csr_data;
            REG_PATTERN_WORD_0:  pattern_words_ff[0] <= csr_data;
            REG_PATTERN_WORD_1:  pattern_words_ff[1] <= csr_data;
            REG_PATTERN_WORD_2:  pattern_words_ff[2] <= csr_data;
            REG_PATTERN_WORD_3:  pattern_words_ff[3] <= csr_data;
            REG_PATTERN_LENGTH:  pattern_length_ff   <= csr_data[LEN_REG_W-1:0];
            REG_WILDCARD_ENABLE: wildcard_enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Scan state. After a match the window and count stand still until the region ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         match_done_ff <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            bytes_seen_ff <= '0;
            match_done_ff <= 1'b0;
         end else if (!match_done_ff) begin
            bytes_seen_ff <= bytes_seen_in;
            match_done_ff <= hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !match_done_ff) begin
         window_ff <= window_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_found_ff <= hit;
         out_addr_ff  <= hit ? match_addr : '0;
      end
   end

endmodule

/* test/tb_wildcard_byte_pattern_scanner.sv */
// Self-checking testbench for the wildcard byte pattern scanner, with scoreboard and stimulus.
module tb_wildcard_byte_pattern_scanner;
   import wbps_pkg::*;

   localparam int WINDOW_BYTES = DEFAULT_MAX_PATTERN_BYTES;
   localparam int RANDOM_BYTES = 500;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } scan_result_type;

   // Tracks the scanner's state byte by byte and holds the results still owed by the block.
   class scan_scoreboard;
      logic [ADDR_W-1:0]    base_addr = '0;
      pattern_words_type    words     = '0;
      logic [LEN_REG_W-1:0] pat_len   = 6'd1;
      logic                 wild_on   = 1'b1;
      bit [7:0]             window [WINDOW_BYTES];
      logic [63:0]          seen      = '0;
      logic                 matched   = 1'b0;
      scan_result_type      awaited [$];
      int                   errors    = 0;

      function logic [7:0] pattern_at(int j);
         return words[j >> 3][(j & 7) * 8 +: 8];
      endfunction

      // A length of zero behaves as one, and anything past the window as the window size.
      function int active_len();
         int len;
         len = int'(pat_len);
         if (len == 0) len = 1;
         if (len > WINDOW_BYTES) len = WINDOW_BYTES;
         return len;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_REGION_BASE:     base_addr = val;
            REG_PATTERN_WORD_0:  words[0]  = val;
            REG_PATTERN_WORD_1:  words[1]  = val;
            REG_PATTERN_WORD_2:  words[2]  = val;
            REG_PATTERN_WORD_3:  words[3]  = val;
            REG_PATTERN_LENGTH:  pat_len   = val[LEN_REG_W-1:0];
            REG_WILDCARD_ENABLE: wild_on   = val[0];
            default: ;
         endcase
      endfunction

      // Called for every accepted byte beat; queues the result the byte causes, if any.
      function void note_byte(logic [7:0] data, logic last);
         int              len;
         int              i;
         logic            hit;
         logic [7:0]      p;
         scan_result_type res;
         if (!matched) begin
            len = active_len();
            for (i = WINDOW_BYTES - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = data;
            if (seen != '1) seen++;
            hit = (seen >= 64'(len));
            for (i = 0; i < len; i++) begin
               p = pattern_at(i);
               if (!(wild_on && p == WILDCARD_BYTE) && p != window[len-1-i]) hit = 1'b0;
            end
            if (hit) begin
               res.found         = 1'b1;
               res.match_address = base_addr + (seen - 64'(len));
               awaited.push_back(res);
               matched = 1'b1;
            end else if (last) begin
               res = '0;
               awaited.push_back(res);
            end
         end
         if (last) begin
            seen    = '0;
            matched = 1'b0;
         end
      endfunction

      function void check_result(logic found, logic [ADDR_W-1:0] addr);
         scan_result_type exp;
         if (awaited.size() == 0) begin
            $error("unexpected result beat: found=%0b match_address=%h", found, addr);
            errors++;
            return;
         end
         exp = awaited.pop_front();
         if (found !== exp.found) begin
            $error("found: expected %0b, actual %0b", exp.found, found);
            errors++;
         end
         if (addr !== exp.match_address) begin
            $error("match_address: expected %h, actual %h", exp.match_address, addr);
            errors++;
         end
      endfunction

      function void report_leftover();
         foreach (awaited[i]) begin
            $error("result never delivered: found=%0b match_address=%h",
                   awaited[i].found, awaited[i].match_address);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata   = '0;   // [7:0] data_byte
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b1;
   logic [ADDR_W-1:0]      rsp_tdata;          // [63:0] match_address
   logic                   rsp_tuser;          // [0] found
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   scan_scoreboard sb = new;

   int bytes_sent = 0;
   int gap_pct    = 0;
   int stall_pct  = 0;
   bit calm       = 1'b0;
   int cycles     = 0;
   int stall_left = 0;

   wildcard_byte_pattern_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The result side stalls in bursts, except in phases without back-pressure and near the end.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 14) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(data, last);
      bytes_sent++;
      calm = (bytes_sent >= 17 + RANDOM_BYTES * 85 / 100);
   endtask

   task automatic idle_req(input int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Drops the byte stream, waits for every owed result, then lets the pipeline settle.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase_config();
      logic [63:0] w;
      logic [7:0]  b;
      int          k;
      int          n;
      case ($urandom_range(0, 3))
         0:       write_csr(REG_REGION_BASE, 64'd0);
         1:       write_csr(REG_REGION_BASE, '1);
         2:       write_csr(REG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40));
         default: write_csr(REG_REGION_BASE, {$urandom, $urandom});
      endcase
      // Pattern bytes are often wildcards or drawn from a narrow alphabet so that partial matches are common.
      for (k = 0; k < PATTERN_WORDS; k++) begin
         for (n = 0; n < 8; n++) begin
            case ($urandom_range(0, 3))
               0:       b = WILDCARD_BYTE;
               1:       b = 8'h41 + 8'($urandom_range(0, 2));
               default: b = 8'($urandom);
            endcase
            w[n*8 +: 8] = b;
         end
         write_csr(REG_PATTERN_WORD_0 + CSR_INDEX_W'(k), w);
      end
      case ($urandom_range(0, 7))
         0:       n = 1;
         1:       n = WINDOW_BYTES;
         2:       n = $urandom_range(9, WINDOW_BYTES - 1);
         default: n = $urandom_range(2, 8);
      endcase
      write_csr(REG_PATTERN_LENGTH, 64'(n));
      write_csr(REG_WILDCARD_ENABLE, 64'($urandom_range(0, 1)));
   endtask

   // One region: background bytes drawn partly from the pattern, optionally with the pattern
   // planted somewhere in it, often right at the end so the match lands on the last byte.
   task automatic scan_region();
      logic [7:0] bytes [$];
      logic [7:0] p;
      int         len;
      int         n;
      int         at;
      int         i;
      len = sb.active_len();
      case ($urandom_range(0, 5))
         0:       n = 1;
         1:       n = (len > 1) ? len - 1 : 1;
         2:       n = len;
         default: n = $urandom_range(len, len + 12);
      endcase
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 1)) bytes.push_back(sb.pattern_at($urandom_range(0, len - 1)));
         else bytes.push_back(8'($urandom));
      end
      if ($urandom_range(0, 9) < 6 && n >= len) begin
         at = ($urandom_range(0, 3) == 0) ? n - len : $urandom_range(0, n - len);
         for (i = 0; i < len; i++) begin
            p = sb.pattern_at(i);
            if (sb.wild_on && p == WILDCARD_BYTE) p = 8'($urandom);
            bytes[at+i] = p;
         end
      end
      for (i = 0; i < n; i++) begin
         if (!calm && $urandom_range(0, 99) < gap_pct) idle_req($urandom_range(1, 14));
         send_byte(bytes[i], i == n - 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a one-byte pattern of 0x00. Match on the second byte, the rest of
      // the region is ignored and its last byte closes it silently.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h55, 1'b1);
      // A single-byte region with no match.
      send_byte(8'hFF, 1'b1);
      wait_drained();

      // Top-of-range base so that the match address wraps; pattern 'A', wildcard, 'C'.
      write_csr(REG_REGION_BASE, '1);
      write_csr(REG_PATTERN_WORD_0, 64'h0000_0000_0043_2A41);
      write_csr(REG_PATTERN_WORD_1, 64'd0);
      write_csr(REG_PATTERN_WORD_2, 64'd0);
      write_csr(REG_PATTERN_WORD_3, 64'd0);
      write_csr(REG_PATTERN_LENGTH, 64'd3);
      write_csr(REG_WILDCARD_ENABLE, 64'd1);
      // Match completed by the last byte of the region.
      send_byte(8'h11, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'h43, 1'b1);
      // Region shorter than the pattern.
      send_byte(8'h41, 1'b0);
      send_byte(8'h2A, 1'b1);
      wait_drained();

      // Exact compare: the asterisk in the pattern now only matches a literal asterisk.
      write_csr(REG_WILDCARD_ENABLE, 64'd0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'h43, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h2A, 1'b0);
      send_byte(8'h43, 1'b1);
      wait_drained();

      while (bytes_sent < 17 + RANDOM_BYTES) begin
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 20;
            default: gap_pct = 50;
         endcase
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            default: stall_pct = 50;
         endcase
         random_phase_config();
         repeat ($urandom_range(2, 6)) scan_region();
         wait_drained();
      end

      sb.report_leftover();
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/wbps_pkg.sv
rtl/wildcard_byte_pattern_scanner.sv
test/tb_wildcard_byte_pattern_scanner.sv
